@@ hw/rtl/fm_chip_timer_status_port_macros.svh @@
// Assertion helpers for the timer port RTL.
`ifndef FM_CHIP_TIMER_STATUS_PORT_MACROS_SVH
`define FM_CHIP_TIMER_STATUS_PORT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FMTMR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmtmr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FMTMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmtmr: next-cycle check failed");

`endif

@@ hw/rtl/fmtmr_pkg.sv @@
package fmtmr_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // Bus ports
  localparam logic [1:0] PORT_ADDR      = 2'd0;
  localparam logic [1:0] PORT_DATA      = 2'd1;
  localparam logic [1:0] PORT_HIGH_ADDR = 2'd2;

  // Timer register numbers
  localparam logic [8:0] REG_TIMER1 = 9'h002;
  localparam logic [8:0] REG_TIMER2 = 9'h003;
  localparam logic [8:0] REG_CTRL   = 9'h004;

  // Control register bits
  localparam int CTRL_STOP_ALL = 7;
  localparam int CTRL_MASK_T1  = 6;
  localparam int CTRL_MASK_T2  = 5;
  localparam int CTRL_EN_T2    = 1;
  localparam int CTRL_EN_T1    = 0;

  // Status byte
  localparam logic [7:0] STAT_ANY       = 8'h80;
  localparam logic [7:0] STAT_T1        = 8'h40;
  localparam logic [7:0] STAT_T2        = 8'h20;
  localparam logic [7:0] STAT_HIGH_BANK = 8'hFF;

  // Configuration registers
  localparam logic CFG_TIMER1_TICK = 1'b0;
  localparam logic CFG_TIMER2_TICK = 1'b1;
  localparam logic [15:0] TIMER1_TICK_RESET = 16'd80;
  localparam logic [15:0] TIMER2_TICK_RESET = 16'd320;

  // Timer arithmetic
  localparam logic [8:0] TIMER_COUNTS = 9'h100;
  localparam int SPAN_W = 25;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  port;
    logic [7:0]  write_value;
    logic [15:0] elapsed_us;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fwd_valid;
    logic [8:0] fwd_reg;
    logic [7:0] fwd_value;
  } result_t;

  typedef struct packed {
    logic [15:0] timer1_tick_us;
    logic [15:0] timer2_tick_us;
  } cfg_t;

endpackage

@@ hw/rtl/fmtmr_in_stage.sv @@
module fmtmr_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fmtmr_pkg::item_t  in_item,
  output logic              s_valid,
  output fmtmr_pkg::item_t  s_item,
  input  logic              s_take
);

  logic             held;
  fmtmr_pkg::item_t item;

  assign in_ready = !held || s_take;
  assign s_valid  = held;
  assign s_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (s_take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ hw/rtl/fmtmr_core.sv @@
`include "fm_chip_timer_status_port_macros.svh"

module fmtmr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  fmtmr_pkg::item_t    item,
  input  fmtmr_pkg::cfg_t     cfg,
  output fmtmr_pkg::result_t  result
);

  logic [8:0]  selected_reg;
  logic [63:0] now_us;
  logic [7:0]  t1_preload;
  logic [7:0]  t2_preload;
  logic        t1_on;
  logic        t2_on;
  logic [63:0] t1_expiry;
  logic [63:0] t2_expiry;

  logic [8:0]  selected_reg_next;
  logic [63:0] now_us_next;
  logic [7:0]  t1_preload_next;
  logic [7:0]  t2_preload_next;
  logic        t1_on_next;
  logic        t2_on_next;
  logic [63:0] t1_expiry_next;
  logic [63:0] t2_expiry_next;

  logic [7:0]                     t1_arm_preload;
  logic [7:0]                     t2_arm_preload;
  logic [8:0]                     t1_counts;
  logic [8:0]                     t2_counts;
  logic [fmtmr_pkg::SPAN_W-1:0]   t1_span;
  logic [fmtmr_pkg::SPAN_W-1:0]   t2_span;
  logic [63:0]                    t1_arm;
  logic [63:0]                    t2_arm;
  logic                           t1_fired;
  logic                           t2_fired;
  logic                           ctrl_stop;

  // A preload write to a running timer re-arms it with the byte being written.
  assign t1_arm_preload = (selected_reg == fmtmr_pkg::REG_TIMER1) ? item.write_value
                                                                  : t1_preload;
  assign t2_arm_preload = (selected_reg == fmtmr_pkg::REG_TIMER2) ? item.write_value
                                                                  : t2_preload;

  assign t1_counts = fmtmr_pkg::TIMER_COUNTS - {1'b0, t1_arm_preload};
  assign t2_counts = fmtmr_pkg::TIMER_COUNTS - {1'b0, t2_arm_preload};
  assign t1_span   = fmtmr_pkg::SPAN_W'(t1_counts) * fmtmr_pkg::SPAN_W'(cfg.timer1_tick_us);
  assign t2_span   = fmtmr_pkg::SPAN_W'(t2_counts) * fmtmr_pkg::SPAN_W'(cfg.timer2_tick_us);
  assign t1_arm    = now_us + 64'(t1_span);
  assign t2_arm    = now_us + 64'(t2_span);

  assign t1_fired  = t1_on && (now_us > t1_expiry);
  assign t2_fired  = t2_on && (now_us > t2_expiry);
  assign ctrl_stop = item.write_value[fmtmr_pkg::CTRL_STOP_ALL];

  always_comb begin
    selected_reg_next = selected_reg;
    now_us_next       = now_us;
    t1_preload_next   = t1_preload;
    t2_preload_next   = t2_preload;
    t1_on_next        = t1_on;
    t2_on_next        = t2_on;
    t1_expiry_next    = t1_expiry;
    t2_expiry_next    = t2_expiry;
    result            = '0;

    case (item.op)
      fmtmr_pkg::OP_WRITE: begin
        case (item.port)
          fmtmr_pkg::PORT_ADDR: begin
            selected_reg_next = {1'b0, item.write_value};
          end
          fmtmr_pkg::PORT_HIGH_ADDR: begin
            selected_reg_next = {1'b1, item.write_value};
          end
          fmtmr_pkg::PORT_DATA: begin
            case (selected_reg)
              fmtmr_pkg::REG_TIMER1: begin
                t1_preload_next = item.write_value;
                if (t1_on) begin
                  t1_expiry_next = t1_arm;
                end
              end
              fmtmr_pkg::REG_TIMER2: begin
                t2_preload_next = item.write_value;
                if (t2_on) begin
                  t2_expiry_next = t2_arm;
                end
              end
              fmtmr_pkg::REG_CTRL: begin
                if (ctrl_stop) begin
                  // Stop both; expiry values stay as they were.
                  t1_on_next = 1'b0;
                  t2_on_next = 1'b0;
                end else begin
                  if (!item.write_value[fmtmr_pkg::CTRL_MASK_T1]) begin
                    t1_on_next = item.write_value[fmtmr_pkg::CTRL_EN_T1];
                    if (item.write_value[fmtmr_pkg::CTRL_EN_T1]) begin
                      t1_expiry_next = t1_arm;
                    end
                  end
                  if (!item.write_value[fmtmr_pkg::CTRL_MASK_T2]) begin
                    t2_on_next = item.write_value[fmtmr_pkg::CTRL_EN_T2];
                    if (item.write_value[fmtmr_pkg::CTRL_EN_T2]) begin
                      t2_expiry_next = t2_arm;
                    end
                  end
                end
              end
              default: begin
                result.fwd_valid = 1'b1;
                result.fwd_reg   = selected_reg;
                result.fwd_value = item.write_value;
              end
            endcase
          end
          default: ;
        endcase
      end
      fmtmr_pkg::OP_READ: begin
        if (item.port == fmtmr_pkg::PORT_HIGH_ADDR) begin
          result.read_data = fmtmr_pkg::STAT_HIGH_BANK;
        end else begin
          if (t1_fired) begin
            result.read_data = result.read_data | fmtmr_pkg::STAT_ANY | fmtmr_pkg::STAT_T1;
          end
          if (t2_fired) begin
            result.read_data = result.read_data | fmtmr_pkg::STAT_ANY | fmtmr_pkg::STAT_T2;
          end
        end
      end
      fmtmr_pkg::OP_ADVANCE: begin
        now_us_next = now_us + 64'(item.elapsed_us);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_reg <= '0;
      now_us       <= '0;
      t1_preload   <= '0;
      t2_preload   <= '0;
      t1_on        <= 1'b0;
      t2_on        <= 1'b0;
      t1_expiry    <= '0;
      t2_expiry    <= '0;
    end else if (fire) begin
      selected_reg <= selected_reg_next;
      now_us       <= now_us_next;
      t1_preload   <= t1_preload_next;
      t2_preload   <= t2_preload_next;
      t1_on        <= t1_on_next;
      t2_on        <= t2_on_next;
      t1_expiry    <= t1_expiry_next;
      t2_expiry    <= t2_expiry_next;
    end
  end

  `FMTMR_ASSERT_NEXT(a_advance_adds, clk, rst, fire && (item.op == fmtmr_pkg::OP_ADVANCE), now_us == $past(now_us) + 64'($past(item.elapsed_us)))
  `FMTMR_ASSERT_NEXT(a_idle_holds, clk, rst, !fire, $stable(now_us) && $stable(t1_on) && $stable(t2_on) && $stable(selected_reg))
  `FMTMR_ASSERT_NEXT(a_stop_all, clk, rst, fire && (item.op == fmtmr_pkg::OP_WRITE) && (item.port == fmtmr_pkg::PORT_DATA) && (selected_reg == fmtmr_pkg::REG_CTRL) && ctrl_stop, !t1_on && !t2_on)
  `FMTMR_ASSERT_SAME(a_fwd_only_write, clk, rst, result.fwd_valid, (item.op == fmtmr_pkg::OP_WRITE) && (result.read_data == 8'h00))

endmodule

@@ hw/rtl/fmtmr_out_stage.sv @@
module fmtmr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                r_valid,
  output logic                r_ready,
  input  fmtmr_pkg::result_t  r_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fmtmr_pkg::result_t  out_data
);

  logic               full;
  fmtmr_pkg::result_t data;

  assign r_ready   = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (r_valid && r_ready) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_valid && r_ready) begin
      data <= r_data;
    end
  end

endmodule

@@ hw/rtl/fm_chip_timer_status_port.sv @@
// Timer section of an FM sound chip register port.
// Input channel (in_valid/in_ready) carries one bus operation per transaction:
// an address write, a data write, a status read or a time advance. Output
// channel (out_valid/out_ready) returns exactly one result per input
// transaction, in order: the status byte for a read, the forwarded register
// write for a non-timer data write, zeros otherwise.
// Configuration: cfg_we writes cfg_data into the tick period selected by
// cfg_index (0 timer one, 1 timer two); write only while the block is idle.
// A transaction is registered at the input stage when accepted; its result
// is computed combinationally by the core and registered at the output
// stage. Throughput: one transaction per cycle while the receiver does not
// stall, set by the combinational update of the timer state (a 9x16
// multiply and a 64-bit add per timer).
// When the receiver stalls, the result holds in the output register and one
// more transaction is still accepted into the input register; further input
// waits until out_ready returns.
// Reset (rst, synchronous) clears the clock, timers and register select and
// loads tick periods of 80 and 320 microseconds.
module fm_chip_timer_status_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [1:0]  port,
  input  logic [7:0]  write_value,
  input  logic [15:0] elapsed_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        fwd_valid,
  output logic [8:0]  fwd_reg,
  output logic [7:0]  fwd_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  fmtmr_pkg::item_t   in_item;
  fmtmr_pkg::item_t   s_item;
  fmtmr_pkg::result_t r_data;
  fmtmr_pkg::result_t out_data;
  fmtmr_pkg::cfg_t    cfg;
  logic               s_valid;
  logic               r_ready;
  logic               s_take;

  assign in_item.op          = op;
  assign in_item.port        = port;
  assign in_item.write_value = write_value;
  assign in_item.elapsed_us  = elapsed_us;

  assign s_take = s_valid && r_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer1_tick_us <= fmtmr_pkg::TIMER1_TICK_RESET;
      cfg.timer2_tick_us <= fmtmr_pkg::TIMER2_TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fmtmr_pkg::CFG_TIMER1_TICK: cfg.timer1_tick_us <= cfg_data;
        fmtmr_pkg::CFG_TIMER2_TICK: cfg.timer2_tick_us <= cfg_data;
        default: ;
      endcase
    end
  end

  fmtmr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_item   (s_item),
    .s_take   (s_take)
  );

  fmtmr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (s_take),
    .item   (s_item),
    .cfg    (cfg),
    .result (r_data)
  );

  fmtmr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .r_valid   (s_valid),
    .r_ready   (r_ready),
    .r_data    (r_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign read_data = out_data.read_data;
  assign fwd_valid = out_data.fwd_valid;
  assign fwd_reg   = out_data.fwd_reg;
  assign fwd_value = out_data.fwd_value;

endmodule
